### sv/gsu_pkg.sv
// Package: shared types and constants for the GSM septet unpacker.
`timescale 1ns / 1ps
package gsu_pkg;

  localparam int SEPTET_W   = 7;
  localparam int OCTET_W    = 8;
  localparam int STORE_W    = 14;
  localparam int HELD_W     = 4;
  localparam int COUNT_W    = 8;
  localparam int FILL_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FILL_BITS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEPTET_COUNT = 1'd1;

  typedef struct packed {
    logic [OCTET_W-1:0] octet;
    logic               first;
  } in_t;

  typedef struct packed {
    logic [SEPTET_W-1:0] septet;
    logic                last;
  } out_t;

  // One octet's worth of results: one or two septets
  typedef struct packed {
    logic [1:0]      n;
    out_t [1:0]      res;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

### sv/gsu_front.sv
// Front end: takes octets, updates the bit store and forms the septets of each octet.
`timescale 1ns / 1ps
module gsu_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gsu_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [gsu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  input  gsu_pkg::in_t                  in_data,
  input  gsu_pkg::q_status_t            q_stat,
  output logic                          in_stall,
  output logic                          q_push,
  output gsu_pkg::q_entry_t             q_wdata
);

  logic [gsu_pkg::FILL_W-1:0]  fill_r;
  logic [gsu_pkg::COUNT_W-1:0] count_r;
  logic [gsu_pkg::STORE_W-1:0] store_r, store_nxt;
  logic [gsu_pkg::HELD_W-1:0]  held_r, held_nxt;
  logic [gsu_pkg::COUNT_W-1:0] emit_r, emit_nxt;

  logic                        accept;
  logic [gsu_pkg::OCTET_W-1:0] byte_v;
  logic [gsu_pkg::HELD_W-1:0]  add_v;
  logic [gsu_pkg::STORE_W-1:0] base_store, st0, st1, st2;
  logic [gsu_pkg::HELD_W-1:0]  base_held, h0, h1, h2;
  logic [gsu_pkg::COUNT_W-1:0] base_emit, e1, e2;
  logic                        take0, take1;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    byte_v     = in_data.first ? (in_data.octet >> fill_r) : in_data.octet;
    add_v      = in_data.first ? (4'd8 - {1'b0, fill_r}) : 4'd8;
    base_store = in_data.first ? '0 : store_r;
    base_held  = in_data.first ? '0 : held_r;
    base_emit  = in_data.first ? '0 : emit_r;

    st0 = base_store | ({{(gsu_pkg::STORE_W - gsu_pkg::OCTET_W){1'b0}}, byte_v} << base_held);
    h0  = base_held + add_v;

    take0 = (base_emit < count_r) && (h0 >= 4'd7);
    e1    = take0 ? base_emit + 8'd1 : base_emit;
    st1   = take0 ? (st0 >> gsu_pkg::SEPTET_W) : st0;
    h1    = take0 ? h0 - 4'd7 : h0;

    take1 = take0 && (e1 < count_r) && (h1 >= 4'd7);
    e2    = take1 ? e1 + 8'd1 : e1;
    st2   = take1 ? (st1 >> gsu_pkg::SEPTET_W) : st1;
    h2    = take1 ? h1 - 4'd7 : h1;

    q_wdata.n             = {take1, take0 && !take1};
    q_wdata.res[0].septet = st0[gsu_pkg::SEPTET_W-1:0];
    q_wdata.res[0].last   = (e1 == count_r);
    q_wdata.res[1].septet = st1[gsu_pkg::SEPTET_W-1:0];
    q_wdata.res[1].last   = (e2 == count_r);

    store_nxt = store_r;
    held_nxt  = held_r;
    emit_nxt  = emit_r;
    if (accept) begin
      emit_nxt = e2;
      // message complete: drop whatever bits remain
      if (e2 >= count_r) begin
        store_nxt = '0;
        held_nxt  = '0;
      end else begin
        store_nxt = st2;
        held_nxt  = h2;
      end
    end
  end

  assign q_push = accept && take0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      count_r <= '0;
      store_r <= '0;
      held_r  <= '0;
      emit_r  <= '0;
    end else begin
      store_r <= store_nxt;
      held_r  <= held_nxt;
      emit_r  <= emit_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          gsu_pkg::REG_FILL_BITS:    fill_r  <= cfg_wdata[gsu_pkg::FILL_W-1:0];
          gsu_pkg::REG_SEPTET_COUNT: count_r <= cfg_wdata[gsu_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### sv/gsu_queue.sv
// Short queue of per-octet septet pairs between front and back end.
`timescale 1ns / 1ps
module gsu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gsu_pkg::q_entry_t   wdata,
  input  logic                pop,
  output gsu_pkg::q_entry_t   rdata,
  output gsu_pkg::q_status_t  stat
);

  gsu_pkg::q_entry_t              slot_r [gsu_pkg::Q_DEPTH];
  logic [gsu_pkg::Q_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [gsu_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == gsu_pkg::Q_CNT_W'(gsu_pkg::Q_DEPTH));
  assign stat.valid = (cnt_r != '0);
  assign rdata      = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

endmodule

### sv/gsu_back.sv
// Back end: sends the queued septets one beat at a time through an output register.
`timescale 1ns / 1ps
module gsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  gsu_pkg::q_status_t q_stat,
  input  gsu_pkg::q_entry_t  q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output gsu_pkg::out_t      out_data
);

  logic          sel_r, sel_nxt;
  logic          out_valid_r, out_valid_nxt;
  gsu_pkg::out_t out_data_r, out_data_nxt;
  logic          load, last_of_entry;

  assign load          = !out_valid_r || !out_stall;
  assign last_of_entry = (q_rdata.n == 2'd1) || sel_r;

  always_comb begin
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = q_stat.valid;
      if (q_stat.valid) begin
        out_data_nxt = q_rdata.res[sel_r];
        // advance to the second septet or release the entry
        if (last_of_entry) begin
          q_pop   = 1'b1;
          sel_nxt = 1'b0;
        end else begin
          sel_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/gsm_septet_unpacker.sv
// Top level: GSM 7-bit septet unpacker, octets in, septets out.
// Path: the septets of an accepted octet pass through the queue and then the output
// register; a second septet from the same octet follows the first.
// Throughput: one octet per cycle while the four-entry queue has room; the output
// register sends one septet per cycle while out_stall is low, so an octet giving two
// septets takes the output longer (eight septets per seven octets sets the long-run pace).
// Reset (rst_n, synchronous): clears registers, bit store, counters and queue.
`timescale 1ns / 1ps
module gsm_septet_unpacker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gsu_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [gsu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gsu_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gsu_pkg::out_t                   out_data
);

  logic               q_push, q_pop;
  gsu_pkg::q_entry_t  q_wdata, q_rdata;
  gsu_pkg::q_status_t q_stat;

  gsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .in_stall  (in_stall),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  gsu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  gsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_head_has_results: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.valid |-> (q_rdata.n == 2'd1 || q_rdata.n == 2'd2))
    else $error("queue entry without septets");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.valid)
    else $error("pop from empty queue");

  a_idle_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_stat.valid && (!out_valid || !out_stall)) |=> !out_valid)
    else $error("septet sent with nothing queued");

endmodule

### tb/gsu_checker.sv
// Checker for the septet unpacker: predicts septets from octet beats and compares them.
`timescale 1ns / 1ps
module gsu_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gsu_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [gsu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  gsu_pkg::in_t                   in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  gsu_pkg::out_t                  out_data,
  output int                             failures,
  output int                             pending
);

  localparam int REPORT_MAX = 10;

  logic [gsu_pkg::FILL_W-1:0]  fill;
  logic [gsu_pkg::COUNT_W-1:0] count;
  logic [gsu_pkg::STORE_W-1:0] store;
  logic [gsu_pkg::HELD_W-1:0]  held;
  logic [gsu_pkg::COUNT_W-1:0] emitted;
  gsu_pkg::out_t               expected_septets[$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  task automatic unpack_octet(input gsu_pkg::in_t beat);
    logic [gsu_pkg::OCTET_W-1:0] data;
    logic [gsu_pkg::HELD_W-1:0]  add;
    gsu_pkg::out_t               res;
    data = beat.octet;
    add  = gsu_pkg::HELD_W'(gsu_pkg::OCTET_W);
    if (beat.first) begin
      store   = '0;
      held    = '0;
      emitted = '0;
      data    = data >> fill;
      add     = gsu_pkg::HELD_W'(gsu_pkg::OCTET_W) - gsu_pkg::HELD_W'(fill);
    end
    if (emitted >= count) begin
      store = '0;
      held  = '0;
      return;
    end
    store = store | (gsu_pkg::STORE_W'(data) << held);
    held  = held + add;
    // held never exceeds 14, so at most two septets leave per octet
    while (held >= gsu_pkg::HELD_W'(gsu_pkg::SEPTET_W) && emitted < count) begin
      res.septet = store[gsu_pkg::SEPTET_W-1:0];
      emitted    = emitted + 1'b1;
      res.last   = (emitted == count);
      expected_septets.push_back(res);
      store = store >> gsu_pkg::SEPTET_W;
      held  = held - gsu_pkg::HELD_W'(gsu_pkg::SEPTET_W);
    end
    if (emitted >= count) begin
      store = '0;
      held  = '0;
    end
  endtask

  always @(posedge clk) begin
    gsu_pkg::out_t want;
    if (!rst_n) begin
      fill    = '0;
      count   = '0;
      store   = '0;
      held    = '0;
      emitted = '0;
      expected_septets.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          gsu_pkg::REG_FILL_BITS: begin
            fill = cfg_wdata[gsu_pkg::FILL_W-1:0];
          end
          gsu_pkg::REG_SEPTET_COUNT: begin
            count = cfg_wdata[gsu_pkg::COUNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        unpack_octet(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_septets.size() == 0) begin
          failures++;
          if (failures <= REPORT_MAX) begin
            $display("unexpected septet beat: septet %0d last %0b",
                     out_data.septet, out_data.last);
          end
        end else begin
          want = expected_septets.pop_front();
          if (want.septet !== out_data.septet || want.last !== out_data.last) begin
            failures++;
            if (failures <= REPORT_MAX) begin
              $display("septet mismatch: expected septet %0d last %0b, got septet %0d last %0b",
                       want.septet, want.last, out_data.septet, out_data.last);
            end
          end
        end
      end
    end
    pending = expected_septets.size();
  end

endmodule

### tb/tb.sv
// Testbench top: drives octet messages and register settings into the unpacker.
`timescale 1ns / 1ps
module tb;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 150;
  localparam int WATCH_LIMIT  = 4000;
  localparam int OCTET_TARGET = 650;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [gsu_pkg::CFG_IDX_W-1:0]  cfg_addr;
  logic [gsu_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  gsu_pkg::in_t                   in_data;
  logic                           out_valid;
  logic                           out_stall;
  gsu_pkg::out_t                  out_data;

  int failures;
  int pending;
  int idle_pct;
  int stall_pct;
  int holds_wanted;
  int holds_done;
  int quiet_cycles;
  int octets_sent;

  gsm_septet_unpacker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  gsu_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .failures  (failures),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver: random stall, plus a long hold-off on request
  initial begin
    out_stall  = 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_wanted) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [gsu_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= gsu_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_octet(input logic [gsu_pkg::OCTET_W-1:0] value, input logic is_first);
    in_valid <= 1'b1;
    in_data  <= gsu_pkg::in_t'{octet: value, first: is_first};
    do @(posedge clk); while (in_stall);
    octets_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Hold the input until every expected septet is out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 71; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 71; end
      default: begin idle_pct = 27; stall_pct = 27; end
    endcase
  endtask

  task automatic send_message(input int unsigned fill, input int unsigned count);
    int unsigned need;
    int unsigned len;
    int unsigned extra;
    int unsigned r;
    need = (count * 7 + fill + 7) / 8;
    if (need == 0) need = 1;
    len   = need;
    extra = 0;
    r     = $urandom_range(99);
    if (r < 10) begin
      len = $urandom_range(need, 1);
    end else if (r < 20) begin
      extra = $urandom_range(3, 1);
    end else if (r < 25) begin
      // stray octets with no first mark
      len   = 0;
      extra = $urandom_range(4, 1);
    end
    for (int unsigned k = 0; k < len; k++) begin
      send_octet(8'($urandom_range(255)), k == 0);
    end
    for (int unsigned k = 0; k < extra; k++) begin
      send_octet(8'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin
    int unsigned fill;
    int unsigned count;
    int unsigned r;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    holds_wanted = 0;
    octets_sent  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No first mark after reset: decode with zero fill
    write_reg(gsu_pkg::REG_SEPTET_COUNT, 5);
    send_octet(8'hFF, 1'b0);
    send_octet(8'h00, 1'b0);
    send_octet(8'hA5, 1'b0);
    send_octet(8'h5A, 1'b0);
    send_octet(8'h81, 1'b0);
    drain();

    // Seven octets give eight septets
    write_reg(gsu_pkg::REG_FILL_BITS, 0);
    write_reg(gsu_pkg::REG_SEPTET_COUNT, 8);
    send_octet(8'hFF, 1'b1);
    send_octet(8'h00, 1'b0);
    send_octet(8'hFF, 1'b0);
    send_octet(8'h55, 1'b0);
    send_octet(8'hAA, 1'b0);
    send_octet(8'h7F, 1'b0);
    send_octet(8'h80, 1'b0);
    drain();

    // Fill of six, then an octet past the end of the message
    write_reg(gsu_pkg::REG_FILL_BITS, 6);
    write_reg(gsu_pkg::REG_SEPTET_COUNT, 2);
    send_octet(8'hC0, 1'b1);
    send_octet(8'hFF, 1'b0);
    send_octet(8'h01, 1'b0);
    send_octet(8'hFF, 1'b0);
    drain();

    // Fill of seven keeps only the top bit of the first octet
    write_reg(gsu_pkg::REG_FILL_BITS, 7);
    write_reg(gsu_pkg::REG_SEPTET_COUNT, 1);
    send_octet(8'h80, 1'b1);
    send_octet(8'h3F, 1'b0);
    drain();

    // Zero count never yields a septet
    write_reg(gsu_pkg::REG_SEPTET_COUNT, 0);
    send_octet(8'hFF, 1'b1);
    send_octet(8'h12, 1'b0);
    drain();

    // Count lowered below what has already left, then raised again
    write_reg(gsu_pkg::REG_FILL_BITS, 0);
    write_reg(gsu_pkg::REG_SEPTET_COUNT, 10);
    send_octet(8'h3C, 1'b1);
    send_octet(8'hC3, 1'b0);
    send_octet(8'h96, 1'b0);
    drain();
    write_reg(gsu_pkg::REG_SEPTET_COUNT, 2);
    send_octet(8'h69, 1'b0);
    drain();
    write_reg(gsu_pkg::REG_SEPTET_COUNT, 10);
    send_octet(8'hE7, 1'b0);
    send_octet(8'h18, 1'b0);
    drain();

    // Long receiver hold-off while the sender keeps offering octets
    set_mode(0);
    write_reg(gsu_pkg::REG_FILL_BITS, 0);
    write_reg(gsu_pkg::REG_SEPTET_COUNT, 40);
    holds_wanted <= holds_wanted + 1;
    for (int k = 0; k < 35; k++) begin
      send_octet(8'($urandom_range(255)), k == 0);
    end
    drain();

    for (int phase = 0; octets_sent < OCTET_TARGET; phase++) begin
      set_mode(phase);
      fill = $urandom_range(7);
      r    = $urandom_range(99);
      if (phase == 1) begin
        fill  = 7;
        count = 255;
      end else if (phase == 2) begin
        fill  = 6;
        count = 255;
      end else if (r < 5) begin
        count = 255;
      end else if (r < 10) begin
        count = 0;
      end else begin
        count = $urandom_range(20, 1);
      end
      write_reg(gsu_pkg::REG_FILL_BITS, fill);
      write_reg(gsu_pkg::REG_SEPTET_COUNT, count);
      for (int m = $urandom_range(4, 1); m > 0 && octets_sent < OCTET_TARGET; m--) begin
        send_message(fill, count);
      end
      drain();
    end

    if (failures == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
